// ===== hw/rtl/tbpf_pkg.sv =====
// shared types and constants of the tile background pixel fetcher
package tbpf_pkg;

   // request codes
   localparam logic [1:0] REQ_BEGIN = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_POP   = 2'd2;

   // fetch phases
   localparam logic [1:0] PHASE_TILE = 2'd0;
   localparam logic [1:0] PHASE_LOW  = 2'd1;
   localparam logic [1:0] PHASE_HIGH = 2'd2;
   localparam logic [1:0] PHASE_PUSH = 2'd3;

   localparam logic [15:0] UNSIGNED_BASE = 16'h8000;
   localparam logic [7:0]  SIGNED_FLIP   = 8'h80;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int ROW_PIXELS          = 8;
   localparam int PIXEL_W             = 2;

   typedef logic [ROW_PIXELS-1:0][PIXEL_W-1:0] pixel_row_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] head_pixel;
      logic               not_empty;
   } queue_status_type;

endpackage

// ===== hw/rtl/tbpf_queue.sv =====
// pixel fifo with a full-row push and a single-pixel pop
module tbpf_queue #(
   parameter int QUEUE_DEPTH = tbpf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tbpf_pkg::queue_ctrl_type        ctrl,
   input  tbpf_pkg::pixel_row_type         push_row,
   output tbpf_pkg::queue_status_type      status,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] count_next
);
   import tbpf_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int SW = $clog2(2 * QUEUE_DEPTH);

   logic [PIXEL_W-1:0] queue_ff [QUEUE_DEPTH];
   logic [IW-1:0]      head_ff;
   logic [IW-1:0]      head_in;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               push_ok;
   logic               pop_ok;
   logic [SW-1:0]      slot_sum [ROW_PIXELS];
   logic [IW-1:0]      slot_idx [ROW_PIXELS];

   // a row only goes in when all eight pixels fit
   assign push_ok = ctrl.push && (count_ff <= CW'(QUEUE_DEPTH - ROW_PIXELS));
   assign pop_ok  = ctrl.pop && (count_ff != '0);

   assign status.head_pixel = queue_ff[head_ff];
   assign status.not_empty  = (count_ff != '0);
   assign count_next        = count_in;

   always_comb begin
      for (int k = 0; k < ROW_PIXELS; k++) begin
         slot_sum[k] = SW'(head_ff) + SW'(count_ff) + SW'(k);
         if (slot_sum[k] >= SW'(QUEUE_DEPTH)) begin
            slot_sum[k] = slot_sum[k] - SW'(QUEUE_DEPTH);
         end
         slot_idx[k] = slot_sum[k][IW-1:0];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (push_ok) begin
         count_in = count_ff + CW'(ROW_PIXELS);
      end else if (pop_ok) begin
         count_in = count_ff - CW'(1);
         if (head_ff == IW'(QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push_ok && !ctrl.clear) begin
         for (int k = 0; k < ROW_PIXELS; k++) begin
            queue_ff[slot_idx[k]] <= push_row[k];
         end
      end
   end

endmodule

// ===== hw/rtl/tile_background_pixel_fetcher.sv =====
// tile background pixel fetcher: an accepted request's result is registered and shown in the next cycle
// throughput: one transaction per cycle while the result is not stalled downstream, set by the single result register
// a new request is taken while the previous result is being taken downstream
// all fetch state is updated in the cycle a request is accepted
// reset (synchronous) clears the phase, tick divider, bases, row planes and fifo count
// fifo storage has no reset; it is only read where it was written
module tile_background_pixel_fetcher #(
   parameter int QUEUE_DEPTH = tbpf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_tile_data_base,
   input  logic [15:0] req_map_base,
   input  logic [2:0]  req_row_in_tile,
   input  logic [7:0]  req_read_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_address,
   output logic [1:0]  rsp_pixel,
   output logic        rsp_pixel_valid,
   output logic [4:0]  rsp_fifo_count,
   output logic [1:0]  rsp_fetch_phase
);
   import tbpf_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // handshake
   logic accept;

   // fetch state
   logic        div_ff, div_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  column_ff, column_in;
   logic [7:0]  tile_ff, tile_in;
   logic [15:0] data_base_ff, data_base_in;
   logic [15:0] map_base_ff, map_base_in;
   logic [2:0]  row_ff, row_in;
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  hi_ff, hi_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_address_ff, rsp_address_in;
   logic [1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic        rsp_pixel_valid_ff, rsp_pixel_valid_in;
   logic [4:0]  rsp_count_ff, rsp_count_in;
   logic [1:0]  rsp_phase_ff, rsp_phase_in;

   // fifo
   queue_ctrl_type   q_ctrl;
   queue_status_type q_status;
   pixel_row_type    push_row;
   logic [CW-1:0]    q_count_next;

   // address path
   logic [7:0]  tile_id;
   logic [15:0] tile_row_addr;

   // result register frees up when empty or being taken this cycle
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // leftmost pixel (bit 7 of both planes) goes into the fifo first
   always_comb begin
      for (int k = 0; k < ROW_PIXELS; k++) begin
         push_row[k] = {hi_ff[ROW_PIXELS-1-k], lo_ff[ROW_PIXELS-1-k]};
      end
   end

   // next fetch state and fifo commands
   always_comb begin
      div_in       = div_ff;
      phase_in     = phase_ff;
      column_in    = column_ff;
      tile_in      = tile_ff;
      data_base_in = data_base_ff;
      map_base_in  = map_base_ff;
      row_in       = row_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      q_ctrl       = '0;
      if (accept) begin
         case (req_type)
            REQ_BEGIN: begin
               // new line: latch bases, restart at column zero, empty fifo
               data_base_in = req_tile_data_base;
               map_base_in  = req_map_base;
               row_in       = req_row_in_tile;
               phase_in     = PHASE_TILE;
               column_in    = '0;
               tile_in      = '0;
               q_ctrl.clear = 1'b1;
            end
            REQ_TICK: begin
               if (!div_ff) begin
                  // resting tick
                  div_in = 1'b1;
               end else begin
                  div_in = 1'b0;
                  case (phase_ff)
                     PHASE_TILE: begin
                        tile_in  = req_read_data;
                        phase_in = PHASE_LOW;
                     end
                     PHASE_LOW: begin
                        lo_in    = req_read_data;
                        hi_in    = '0;
                        phase_in = PHASE_HIGH;
                     end
                     PHASE_HIGH: begin
                        hi_in    = req_read_data;
                        phase_in = PHASE_PUSH;
                     end
                     default: begin
                        // push phase: row is dropped when fewer than eight slots are free,
                        // column advances anyway
                        q_ctrl.push = 1'b1;
                        column_in   = column_ff + 8'd1;
                        phase_in    = PHASE_TILE;
                     end
                  endcase
               end
            end
            REQ_POP: begin
               q_ctrl.pop = 1'b1;
            end
            default: begin
               // unused code, nothing changes
            end
         endcase
      end
   end

   // address that the next acting tick reads, from the updated state
   always_comb begin
      tile_id = tile_in;
      if (data_base_in != UNSIGNED_BASE) begin
         tile_id = tile_in ^ SIGNED_FLIP;
      end
      tile_row_addr = data_base_in + {4'b0000, tile_id, 4'b0000}
                    + {12'b0, row_in, 1'b0};
      case (phase_in)
         PHASE_TILE: rsp_address_in = map_base_in + {8'b0, column_in};
         PHASE_LOW:  rsp_address_in = tile_row_addr;
         PHASE_HIGH: rsp_address_in = tile_row_addr + 16'd1;
         default:    rsp_address_in = '0;
      endcase
   end

   // rest of the result
   always_comb begin
      rsp_pixel_in       = '0;
      rsp_pixel_valid_in = 1'b0;
      if (q_ctrl.pop && q_status.not_empty) begin
         rsp_pixel_in       = q_status.head_pixel;
         rsp_pixel_valid_in = 1'b1;
      end
      rsp_count_in = q_count_next[4:0];
      rsp_phase_in = phase_in;
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   tbpf_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (q_ctrl),
      .push_row   (push_row),
      .status     (q_status),
      .count_next (q_count_next)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff       <= 1'b0;
         phase_ff     <= PHASE_TILE;
         column_ff    <= '0;
         tile_ff      <= '0;
         data_base_ff <= '0;
         map_base_ff  <= '0;
         row_ff       <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_ff       <= div_in;
         phase_ff     <= phase_in;
         column_ff    <= column_in;
         tile_ff      <= tile_in;
         data_base_ff <= data_base_in;
         map_base_ff  <= map_base_in;
         row_ff       <= row_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded once per accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_address_ff     <= rsp_address_in;
         rsp_pixel_ff       <= rsp_pixel_in;
         rsp_pixel_valid_ff <= rsp_pixel_valid_in;
         rsp_count_ff       <= rsp_count_in;
         rsp_phase_ff       <= rsp_phase_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_address = rsp_address_ff;
   assign rsp_pixel        = rsp_pixel_ff;
   assign rsp_pixel_valid  = rsp_pixel_valid_ff;
   assign rsp_fifo_count   = rsp_count_ff;
   assign rsp_fetch_phase  = rsp_phase_ff;

`ifndef SYNTHESIS
   a_rest_tick_holds_phase: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_TICK && !div_ff) |=> $stable(phase_ff))
      else $error("resting tick changed the fetch phase");

   a_pop_gives_pixel: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_POP && q_status.not_empty) |=> rsp_pixel_valid)
      else $error("pop on a nonempty fifo returned no pixel");

   a_begin_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_BEGIN)
      |=> (rsp_fifo_count == 5'd0 && rsp_fetch_phase == PHASE_TILE && column_ff == 8'd0))
      else $error("begin did not restart the fetch");

   a_push_reads_nothing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fetch_phase == PHASE_PUSH) |-> (rsp_read_address == 16'd0))
      else $error("push phase reported a read address");

   a_pixel_only_on_pop: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type != REQ_POP) |=> !rsp_pixel_valid)
      else $error("pixel reported without a pop");
`endif

endmodule
